[src/vnba_pkg.sv]
// ============================================================================
// vnba_pkg
// Types, constants and anchor tables for the VU needle ballistics block.
// ============================================================================
package vnba_pkg;

    localparam int LEVEL_IN_W = 16;
    localparam int LEVEL_W    = 14;
    localparam int ANGLE_W    = 15;
    localparam int ANGLE_X_W  = 17;
    localparam int GAIN_W     = 16;
    localparam int DBAND_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SEG_W      = 4;
    localparam int OFF_W      = 12;
    localparam int DELTA_W    = 13;
    localparam int DEN_W      = 12;
    localparam int QUO_W      = 13;
    localparam int MUL_W      = 16;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DVD_W      = 24;

    localparam int NUM_ANCHORS = 11;
    localparam int NUM_SEGS    = NUM_ANCHORS - 1;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_GAIN  = 2'd0,
        CFG_RELEASE_GAIN = 2'd1,
        CFG_DEADBAND     = 2'd2
    } cfg_index_t;

    localparam logic [GAIN_W-1:0]  ATTACK_GAIN_RST  = 16'd15729;
    localparam logic [GAIN_W-1:0]  RELEASE_GAIN_RST = 16'd6554;
    localparam logic [DBAND_W-1:0] DEADBAND_RST     = 8'd2;

    localparam logic signed [LEVEL_IN_W-1:0] LEVEL_IN_MIN = -16'sd7680;
    localparam logic signed [LEVEL_IN_W-1:0] LEVEL_IN_MAX = 16'sd1024;
    localparam logic signed [LEVEL_W-1:0]    LEVEL_MIN    = -14'sd7680;
    localparam logic signed [LEVEL_W-1:0]    LEVEL_MAX    = 14'sd1024;
    localparam logic signed [ANGLE_W-1:0]    ANGLE_MIN    = -15'sd14336;
    localparam logic signed [ANGLE_W-1:0]    ANGLE_MAX    = 15'sd10240;

    // end regions: angle = 2 * level + bias, clamped
    localparam logic signed [ANGLE_X_W-1:0] ANGLE_MIN_X = -17'sd14336;
    localparam logic signed [ANGLE_X_W-1:0] ANGLE_MAX_X = 17'sd10240;
    localparam logic signed [ANGLE_X_W-1:0] ANG_LO_BIAS = -17'sd2560;
    localparam logic signed [ANGLE_X_W-1:0] ANG_HI_BIAS = 17'sd8192;

    localparam logic [PROD_W:0] ROUND_HALF = 33'd32768;

    localparam logic signed [LEVEL_W-1:0] ANCHOR_DB [0:NUM_ANCHORS-1] = '{
        -14'sd5120, -14'sd2560, -14'sd1792, -14'sd1280, -14'sd768, -14'sd512,
        -14'sd256, 14'sd0, 14'sd256, 14'sd512, 14'sd768
    };

    localparam logic signed [ANGLE_W-1:0] ANCHOR_ANG [0:NUM_ANCHORS-1] = '{
        -15'sd12800, -15'sd7424, -15'sd5376, -15'sd3584, -15'sd1792, -15'sd512,
        15'sd768, 15'sd2304, 15'sd4608, 15'sd7168, 15'sd9728
    };

    localparam logic [DELTA_W-1:0] SEG_DELTA [0:NUM_SEGS-1] = '{
        13'd5376, 13'd2048, 13'd1792, 13'd1792, 13'd1280,
        13'd1280, 13'd1536, 13'd2304, 13'd2560, 13'd2560
    };

    localparam logic [DEN_W-1:0] SEG_DEN [0:NUM_SEGS-1] = '{
        12'd2560, 12'd768, 12'd512, 12'd512, 12'd256,
        12'd256, 12'd256, 12'd256, 12'd256, 12'd256
    };

    // segment of an interior level: number of inner anchors at or below it
    function automatic logic [SEG_W-1:0] seg_of(input logic signed [LEVEL_W-1:0] d);
        logic [SEG_W-1:0] s;
        s = '0;
        for (int k = 1; k < NUM_SEGS; k++) begin
            if (d >= ANCHOR_DB[k]) begin
                s = SEG_W'(k);
            end
        end
        return s;
    endfunction

endpackage

[src/vnba_item_if.sv]
// ============================================================================
// vnba_item_if
// Input item channel: command and level.
// ============================================================================
interface vnba_item_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     cmd;
    logic signed [vnba_pkg::LEVEL_IN_W-1:0]   level;

    modport source (output valid, output cmd, output level, input ready);
    modport sink   (input valid, input cmd, input level, output ready);
endinterface

[src/vnba_result_if.sv]
// ============================================================================
// vnba_result_if
// Result channel: shown level, needle angle and moved flag.
// ============================================================================
interface vnba_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [vnba_pkg::LEVEL_W-1:0]   shown_level;
    logic signed [vnba_pkg::ANGLE_W-1:0]   needle_angle;
    logic                                  moved;

    modport source (output valid, output shown_level, output needle_angle,
                    output moved, input ready);
    modport sink   (input valid, input shown_level, input needle_angle,
                    input moved, output ready);
endinterface

[src/vnba_cfg_if.sv]
// ============================================================================
// vnba_cfg_if
// Register write channel: index and data.
// ============================================================================
interface vnba_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [vnba_pkg::CFG_IDX_W-1:0]      index;
    logic [vnba_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/vnba_mul.sv]
// ============================================================================
// vnba_mul
// Unsigned radix-4 serial multiplier, two multiplier bits per cycle.
// ============================================================================
module vnba_mul
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [vnba_pkg::MUL_W-1:0]   a,
    input  logic [vnba_pkg::MUL_W-1:0]   b,
    output logic [vnba_pkg::PROD_W-1:0]  prod,
    output logic                         done
);
    import vnba_pkg::*;

    localparam int STEPS = MUL_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic [MUL_W-1:0]  a_reg;
    logic [PROD_W-1:0] p_reg;
    logic [PROD_W-1:0] p_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MUL_W+1:0]  pp;
    logic [MUL_W+1:0]  sum;

    always_comb
    begin
        pp     = (p_reg[0] ? {2'b00, a_reg} : '0) + (p_reg[1] ? {1'b0, a_reg, 1'b0} : '0);
        sum    = {2'b00, p_reg[PROD_W-1:MUL_W]} + pp;
        p_next = {sum, p_reg[MUL_W-1:2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= {{MUL_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
        end
    end

    assign prod = p_reg;
    assign done = done_reg;

endmodule

[src/vnba_div.sv]
// ============================================================================
// vnba_div
// Restoring serial divider, one quotient bit per cycle.
// ============================================================================
module vnba_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [vnba_pkg::DVD_W-1:0]   dividend,
    input  logic [vnba_pkg::DEN_W-1:0]   divisor,
    output logic [vnba_pkg::QUO_W-1:0]   quotient,
    output logic                         done
);
    import vnba_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [QUO_W-1:0] q_reg;
    logic [QUO_W-1:0] q_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] diff;
    logic             fits;

    always_comb
    begin
        trial    = {rem_reg, q_reg[QUO_W-1]};
        diff     = {1'b0, trial} - {2'b00, den_reg};
        fits     = !diff[DEN_W+1];
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        q_next   = {q_reg[QUO_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DEN_W'(dividend[DVD_W-1:QUO_W]);
            q_reg   <= dividend[QUO_W-1:0];
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

[src/vu_needle_ballistics_angle.sv]
// ============================================================================
// vu_needle_ballistics_angle
// VU meter needle driver: target set, ballistic tick and needle angle.
// ============================================================================
// One transaction at a time. A transaction that needs no step, and whose shown
// level sits at or beyond an end anchor, gets its angle in S_ANG_SETUP and goes
// straight to S_FINISH. A tick whose gap exceeds the deadband adds a pass of the
// shared radix-4 multiplier (gap times gain) and the S_STEP_APPLY state to apply
// the step. An interior angle adds a second multiplier pass and a serial divide.
// The next transaction is accepted while a finished result waits. Register
// writes are always taken.
module vu_needle_ballistics_angle
(
    input  logic                 clk,
    input  logic                 rst_n,
    vnba_item_if.sink            item,
    vnba_result_if.source        result,
    vnba_cfg_if.sink             cfg
);
    import vnba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP_MUL,
        S_STEP_APPLY,
        S_ANG_SETUP,
        S_ANG_MUL,
        S_ANG_DIV,
        S_FINISH
    } state_t;

    state_t                    state_reg;

    logic [GAIN_W-1:0]         attack_gain_reg;
    logic [GAIN_W-1:0]         release_gain_reg;
    logic [DBAND_W-1:0]        deadband_reg;

    logic signed [LEVEL_W-1:0] target_reg;
    logic signed [LEVEL_W-1:0] shown_reg;
    logic [LEVEL_W-1:0]        mag_reg;
    logic                      rising_reg;
    logic [LEVEL_W-1:0]        step_reg;
    logic                      moved_reg;
    logic [SEG_W-1:0]          seg_reg;
    logic signed [ANGLE_W-1:0] angle_reg;

    logic                      mul_start_reg;
    logic [MUL_W-1:0]          mul_a_reg;
    logic [MUL_W-1:0]          mul_b_reg;
    logic                      div_start_reg;
    logic [DVD_W-1:0]          dividend_reg;

    logic                      result_valid_reg;
    logic signed [LEVEL_W-1:0] out_shown_reg;
    logic signed [ANGLE_W-1:0] out_angle_reg;
    logic                      out_moved_reg;

    logic [PROD_W-1:0]         mul_prod;
    logic                      mul_done;
    logic [QUO_W-1:0]          div_quo;
    logic                      div_done;

    logic signed [LEVEL_W-1:0]   level_clamped;
    logic signed [LEVEL_W:0]     gap;
    logic signed [LEVEL_W:0]     gap_neg;
    logic [LEVEL_W-1:0]          gap_mag;
    logic                        gap_rising;
    logic [PROD_W:0]             rnd;
    logic [PROD_W-LEVEL_IN_W:0]  step_full;
    logic [LEVEL_W-1:0]          step_clamped;
    logic [LEVEL_W-1:0]          shown_stepped;
    logic [SEG_W-1:0]            seg;
    logic [LEVEL_W-1:0]          off_w;
    logic [OFF_W-1:0]            off;
    logic                        seg_low;
    logic                        seg_high;
    logic signed [ANGLE_X_W-1:0] d_ext;
    logic signed [ANGLE_X_W-1:0] a_low_w;
    logic signed [ANGLE_X_W-1:0] a_high_w;
    logic signed [ANGLE_W-1:0]   angle_low;
    logic signed [ANGLE_W-1:0]   angle_high;
    logic [DVD_W-1:0]            dividend;
    logic signed [ANGLE_W-1:0]   angle_mid;

    vnba_mul u_mul
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start_reg),
        .a        (mul_a_reg),
        .b        (mul_b_reg),
        .prod     (mul_prod),
        .done     (mul_done)
    );

    vnba_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (dividend_reg),
        .divisor  (SEG_DEN[seg_reg]),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_comb
    begin
        priority if (item.level < LEVEL_IN_MIN)
            level_clamped = LEVEL_MIN;
        else if (item.level > LEVEL_IN_MAX)
            level_clamped = LEVEL_MAX;
        else
            level_clamped = item.level[LEVEL_W-1:0];

        gap        = {target_reg[LEVEL_W-1], target_reg} - {shown_reg[LEVEL_W-1], shown_reg};
        gap_neg    = -gap;
        gap_mag    = gap[LEVEL_W] ? gap_neg[LEVEL_W-1:0] : gap[LEVEL_W-1:0];
        gap_rising = !gap[LEVEL_W];

        rnd          = {1'b0, mul_prod} + ROUND_HALF;
        step_full    = rnd[PROD_W:LEVEL_IN_W];
        step_clamped = (step_full > {3'b000, mag_reg}) ? mag_reg : step_full[LEVEL_W-1:0];
        shown_stepped = rising_reg ? (shown_reg + step_reg) : (shown_reg - step_reg);

        seg      = seg_of(shown_reg);
        off_w    = shown_reg - ANCHOR_DB[seg];
        off      = off_w[OFF_W-1:0];
        seg_low  = shown_reg <= ANCHOR_DB[0];
        seg_high = shown_reg >= ANCHOR_DB[NUM_ANCHORS-1];

        d_ext    = {{(ANGLE_X_W-LEVEL_W){shown_reg[LEVEL_W-1]}}, shown_reg};
        a_low_w  = (d_ext <<< 1) + ANG_LO_BIAS;
        a_high_w = (d_ext <<< 1) + ANG_HI_BIAS;
        angle_low  = (a_low_w < ANGLE_MIN_X) ? ANGLE_MIN : a_low_w[ANGLE_W-1:0];
        angle_high = (a_high_w > ANGLE_MAX_X) ? ANGLE_MAX : a_high_w[ANGLE_W-1:0];

        dividend  = mul_prod[DVD_W-1:0] + DVD_W'(SEG_DEN[seg_reg][DEN_W-1:1]);
        angle_mid = ANCHOR_ANG[seg_reg] + $signed({2'b00, div_quo});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_gain_reg  <= ATTACK_GAIN_RST;
            release_gain_reg <= RELEASE_GAIN_RST;
            deadband_reg     <= DEADBAND_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ATTACK_GAIN:  attack_gain_reg  <= cfg.data;
                CFG_RELEASE_GAIN: release_gain_reg <= cfg.data;
                CFG_DEADBAND:     deadband_reg     <= cfg.data[DBAND_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            target_reg       <= LEVEL_MIN;
            shown_reg        <= LEVEL_MIN;
            mag_reg          <= '0;
            rising_reg       <= 1'b0;
            step_reg         <= '0;
            moved_reg        <= 1'b0;
            seg_reg          <= '0;
            angle_reg        <= '0;
            mul_start_reg    <= 1'b0;
            mul_a_reg        <= '0;
            mul_b_reg        <= '0;
            div_start_reg    <= 1'b0;
            dividend_reg     <= '0;
            result_valid_reg <= 1'b0;
            out_shown_reg    <= '0;
            out_angle_reg    <= '0;
            out_moved_reg    <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (result_valid_reg && result.ready)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        if (item.cmd == CMD_SET)
                        begin
                            target_reg <= level_clamped;
                            moved_reg  <= 1'b0;
                            state_reg  <= S_ANG_SETUP;
                        end
                        else if (gap_mag > {{(LEVEL_W-DBAND_W){1'b0}}, deadband_reg})
                        begin
                            mag_reg       <= gap_mag;
                            rising_reg    <= gap_rising;
                            mul_a_reg     <= gap_rising ? attack_gain_reg : release_gain_reg;
                            mul_b_reg     <= MUL_W'(gap_mag);
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_STEP_MUL;
                        end
                        else
                        begin
                            moved_reg <= 1'b0;
                            state_reg <= S_ANG_SETUP;
                        end
                    end
                end

                S_STEP_MUL:
                begin
                    if (mul_done)
                    begin
                        step_reg  <= step_clamped;
                        state_reg <= S_STEP_APPLY;
                    end
                end

                S_STEP_APPLY:
                begin
                    shown_reg <= $signed(shown_stepped);
                    moved_reg <= (step_reg != '0);
                    state_reg <= S_ANG_SETUP;
                end

                S_ANG_SETUP:
                begin
                    priority if (seg_low)
                    begin
                        angle_reg <= angle_low;
                        state_reg <= S_FINISH;
                    end
                    else if (seg_high)
                    begin
                        angle_reg <= angle_high;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        seg_reg       <= seg;
                        mul_a_reg     <= MUL_W'(SEG_DELTA[seg]);
                        mul_b_reg     <= MUL_W'(off);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_ANG_MUL;
                    end
                end

                S_ANG_MUL:
                begin
                    if (mul_done)
                    begin
                        dividend_reg  <= dividend;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_ANG_DIV;
                    end
                end

                S_ANG_DIV:
                begin
                    if (div_done)
                    begin
                        angle_reg <= angle_mid;
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    if (!result_valid_reg || result.ready)
                    begin
                        result_valid_reg <= 1'b1;
                        out_shown_reg    <= shown_reg;
                        out_angle_reg    <= angle_reg;
                        out_moved_reg    <= moved_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item.ready          = (state_reg == S_IDLE);
    assign cfg.ready           = 1'b1;
    assign result.valid        = result_valid_reg;
    assign result.shown_level  = out_shown_reg;
    assign result.needle_angle = out_angle_reg;
    assign result.moved        = out_moved_reg;

endmodule

[src/vnba_chk.sv]
// ============================================================================
// vnba_chk
// Port-level checks on the result channel, bound to the top level.
// ============================================================================
module vnba_chk
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  result_valid,
    input logic                                  result_ready,
    input logic signed [vnba_pkg::LEVEL_W-1:0]   shown_level,
    input logic signed [vnba_pkg::ANGLE_W-1:0]   needle_angle,
    input logic                                  moved
);
    import vnba_pkg::*;

    logic signed [LEVEL_W-1:0] prev_shown_reg;

    // shown level carried by the last delivered transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_shown_reg <= LEVEL_MIN;
        end
        else if (result_valid && result_ready)
        begin
            prev_shown_reg <= shown_level;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(shown_level)
            && $stable(needle_angle) && $stable(moved))
        else $error("result changed while stalled");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> shown_level >= LEVEL_MIN && shown_level <= LEVEL_MAX)
        else $error("shown level out of range");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> needle_angle >= ANGLE_MIN && needle_angle <= ANGLE_MAX)
        else $error("needle angle out of range");

    a_moved_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> moved == (shown_level != prev_shown_reg))
        else $error("moved flag disagrees with shown level change");

endmodule

bind vu_needle_ballistics_angle vnba_chk u_vnba_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .shown_level  (result.shown_level),
    .needle_angle (result.needle_angle),
    .moved        (result.moved)
);
